// ===== design/bfha_pkg.sv =====
// Shared widths, codes and defaults for the best-fit heap allocator.
package bfha_pkg;

  // Default heap size in bytes.
  localparam int unsigned HEAP_BYTES_DEF = 4096;

  // Payload field widths of the request and response channels.
  localparam int unsigned REQ_BYTES_W = 13;
  localparam int unsigned POFF_W      = 12;
  localparam int unsigned ROFF_W      = 12;
  localparam int unsigned STATUS_W    = 3;

  // Request actions.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_BADSIZE = 3'd2,
    ST_BADPTR  = 3'd3,
    ST_FREED   = 3'd4
  } status_t;

endpackage

// ===== design/bfha_req_if.sv =====
// Request channel of the heap allocator: action, size and pointer to free.
interface bfha_req_if import bfha_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [REQ_BYTES_W-1:0] request_bytes;
  logic [POFF_W-1:0]      payload_offset;

  modport source (output valid, action, request_bytes, payload_offset, input ready);
  modport sink (input valid, action, request_bytes, payload_offset, output ready);
endinterface

// ===== design/bfha_rsp_if.sv =====
// Response channel of the heap allocator: payload offset and status.
interface bfha_rsp_if import bfha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ROFF_W-1:0]   result_offset;
  logic [STATUS_W-1:0] status;

  modport source (output valid, result_offset, status, input ready);
  modport sink (input valid, result_offset, status, output ready);
endinterface

// ===== design/bfha_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module bfha_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/best_fit_heap_allocator.sv =====
// Best-fit heap allocator: implicit block list with boundary tags held in one word RAM.
//
// The heap lives in a RAM of HEAP_BYTES/4 words, each header holding a block size in
// multiples of 8 plus an allocated bit and a previous-allocated bit, with an end mark
// closing the list. After reset a clearing pass over all HEAP_BYTES/4 words builds the
// initial heap and no request is taken until it ends. An allocate walks every block
// header, one header per cycle through the RAM read port. A free walks the list up to
// and including the block being freed, then the free blocks after it plus the block that
// ends the merge, then checks each header and reads each footer of the backward merge,
// and ends with acceptance, header and footer writes and hand-off. A zero size or a null,
// misaligned or out-of-range pointer is refused without a walk; a pointer that is not on
// the list, or that names a block already free, is refused once the walk reaches or
// passes it. One request is handled at a time; a finished response waits in an output
// register, so the next request may be taken before the previous response has been
// transferred.
module best_fit_heap_allocator import bfha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bfha_req_if.sink      req,
  bfha_rsp_if.source    rsp
);

  localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
  localparam int unsigned IDX_W      = $clog2(HEAP_WORDS);
  localparam int unsigned WORD_W     = $clog2(HEAP_BYTES);
  localparam int unsigned CW         = (WORD_W + 1 > 14) ? WORD_W + 1 : 14;

  localparam logic [CW-1:0]     FIRST_HDR = CW'(4);
  localparam logic [CW-1:0]     END_OFF   = CW'(HEAP_BYTES - 4);
  localparam logic [IDX_W-1:0]  IDX_HDR   = IDX_W'(1);
  localparam logic [IDX_W-1:0]  IDX_FTR   = IDX_W'(HEAP_WORDS - 2);
  localparam logic [IDX_W-1:0]  IDX_END   = IDX_W'(HEAP_WORDS - 1);
  localparam logic [WORD_W-1:0] INIT_HDR  = WORD_W'(HEAP_BYTES - 8 + 2);
  localparam logic [WORD_W-1:0] INIT_FTR  = WORD_W'(HEAP_BYTES - 8);
  localparam logic [WORD_W-1:0] INIT_END  = WORD_W'(1);

  typedef enum logic [18:0] {
    S_CLEAR  = 19'h00001,
    S_IDLE   = 19'h00002,
    S_WALK   = 19'h00004,
    S_ADEC   = 19'h00008,
    S_ASPLH  = 19'h00010,
    S_ASPLF  = 19'h00020,
    S_AHDR   = 19'h00040,
    S_ANX    = 19'h00080,
    S_FFIND  = 19'h00100,
    S_FFWD   = 19'h00200,
    S_FWHDR  = 19'h00400,
    S_FWFTR  = 19'h00800,
    S_FWNX   = 19'h01000,
    S_FBHDR  = 19'h02000,
    S_FBPSZ  = 19'h04000,
    S_FBRD   = 19'h08000,
    S_FBWHDR = 19'h10000,
    S_FBWFTR = 19'h20000,
    S_DONE   = 19'h40000
  } state_t;

  // Byte offset to word index.
  function automatic logic [IDX_W-1:0] widx(input logic [CW-1:0] off);
    return off[IDX_W+1:2];
  endfunction

  state_t            state, state_next;
  logic [IDX_W-1:0]  clr_idx, clr_idx_next;
  logic [CW-1:0]     rd_off, rd_off_next;
  logic [CW-1:0]     need, need_next;
  logic [CW-1:0]     hdr, hdr_next;
  logic [CW-1:0]     best, best_next;
  logic [CW-1:0]     bestsz, bestsz_next;
  logic              best_pbit, best_pbit_next;
  logic              found, found_next;
  logic [CW-1:0]     total, total_next;
  logic              h_pbit, h_pbit_next;
  logic [CW-1:0]     nx_val, nx_val_next;
  logic [CW-1:0]     start, start_next;
  logic [ROFF_W-1:0] res_off, res_off_next;
  status_t           res_status, res_status_next;
  logic              out_valid;
  logic [ROFF_W-1:0] out_off;
  status_t           out_status;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic [CW-1:0]     h, sz, nxt, wr_off, wr_val, req_round, p_ext, merged;
  logic              wr_en;

  bfha_ram #(
    .WIDTH (WORD_W),
    .DEPTH (HEAP_WORDS)
  ) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (widx(rd_off_next)),
    .rdata (ram_rdata)
  );

  // The read data always belongs to the offset held in rd_off.
  assign h         = CW'(ram_rdata);
  assign sz        = {h[CW-1:2], 2'b00};
  assign nxt       = rd_off + sz;
  assign req_round = (CW'(req.request_bytes) + CW'(11)) & ~CW'(7);
  assign p_ext     = CW'(req.payload_offset);
  assign merged    = total + hdr - start;

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.result_offset = out_off;
  assign rsp.status        = out_status;

  // Sequencer: list walks, header and footer updates, response hand-off.
  always_comb begin
    state_next      = state;
    clr_idx_next    = clr_idx;
    rd_off_next     = rd_off;
    need_next       = need;
    hdr_next        = hdr;
    best_next       = best;
    bestsz_next     = bestsz;
    best_pbit_next  = best_pbit;
    found_next      = found;
    total_next      = total;
    h_pbit_next     = h_pbit;
    nx_val_next     = nx_val;
    start_next      = start;
    res_off_next    = res_off;
    res_status_next = res_status;
    wr_en           = 1'b0;
    wr_off          = '0;
    wr_val          = '0;
    case (state)
      S_CLEAR: begin
        clr_idx_next = clr_idx + IDX_W'(1);
        if (clr_idx == IDX_END) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        res_off_next = '0;
        if (req.valid) begin
          rd_off_next = FIRST_HDR;
          found_next  = 1'b0;
          if (req.action == ACT_ALLOC) begin
            need_next = req_round;
            if (req.request_bytes == '0) begin
              res_status_next = ST_BADSIZE;
              state_next      = S_DONE;
            end else begin
              state_next = S_WALK;
            end
          end else begin
            hdr_next = p_ext - CW'(4);
            if (p_ext == '0 || p_ext[2:0] != 3'd0 || p_ext >= END_OFF) begin
              res_status_next = ST_BADPTR;
              state_next      = S_DONE;
            end else begin
              state_next = S_FFIND;
            end
          end
        end
      end
      // Best-fit search, one header per cycle.
      S_WALK: begin
        if (sz != '0 && !h[0] && sz >= need && (!found || sz < bestsz)) begin
          found_next     = 1'b1;
          best_next      = rd_off;
          bestsz_next    = sz;
          best_pbit_next = h[1];
        end
        if (sz == '0 || nxt >= END_OFF) begin
          state_next = S_ADEC;
        end else begin
          rd_off_next = nxt;
        end
      end
      S_ADEC: begin
        if (!found) begin
          res_status_next = ST_NOFIT;
          state_next      = S_DONE;
        end else if (bestsz > need) begin
          state_next = S_ASPLH;
        end else begin
          state_next = S_AHDR;
        end
      end
      // Split the remainder off as a new free block.
      S_ASPLH: begin
        wr_en      = 1'b1;
        wr_off     = best + need;
        wr_val     = (bestsz - need) | CW'(2);
        state_next = S_ASPLF;
      end
      S_ASPLF: begin
        wr_en      = 1'b1;
        wr_off     = best + bestsz - CW'(4);
        wr_val     = bestsz - need;
        state_next = S_AHDR;
      end
      S_AHDR: begin
        wr_en       = 1'b1;
        wr_off      = best;
        wr_val      = need | {{(CW-2){1'b0}}, best_pbit, 1'b1};
        rd_off_next = best + need;
        state_next  = S_ANX;
      end
      // Mark the following block's previous-allocated bit.
      S_ANX: begin
        if (rd_off < END_OFF && h != CW'(1)) begin
          wr_en  = 1'b1;
          wr_off = rd_off;
          wr_val = h | CW'(2);
        end
        res_status_next = ST_OK;
        res_off_next    = ROFF_W'(best + CW'(4));
        state_next      = S_DONE;
      end
      // Look for the header of the block being freed.
      S_FFIND: begin
        if (rd_off == hdr) begin
          if (!h[0]) begin
            res_status_next = ST_FREED;
            state_next      = S_DONE;
          end else begin
            h_pbit_next = h[1];
            total_next  = sz;
            rd_off_next = hdr + sz;
            state_next  = ((hdr + sz) < END_OFF) ? S_FFWD : S_FWHDR;
          end
        end else if (sz == '0 || rd_off > hdr || nxt >= END_OFF) begin
          res_status_next = ST_BADPTR;
          state_next      = S_DONE;
        end else begin
          rd_off_next = nxt;
        end
      end
      // Absorb the free blocks that follow.
      S_FFWD: begin
        if (h[0] || sz == '0) begin
          nx_val_next = h;
          state_next  = S_FWHDR;
        end else begin
          total_next  = total + sz;
          rd_off_next = nxt;
          if (nxt >= END_OFF) begin
            state_next = S_FWHDR;
          end
        end
      end
      S_FWHDR: begin
        wr_en      = 1'b1;
        wr_off     = hdr;
        wr_val     = total | {{(CW-2){1'b0}}, h_pbit, 1'b0};
        state_next = S_FWFTR;
      end
      S_FWFTR: begin
        wr_en      = 1'b1;
        wr_off     = hdr + total - CW'(4);
        wr_val     = total;
        state_next = S_FWNX;
      end
      S_FWNX: begin
        if (rd_off < END_OFF) begin
          wr_en  = 1'b1;
          wr_off = rd_off;
          wr_val = (nx_val & ~CW'(3)) | CW'(1);
        end
        start_next = hdr;
        if (hdr > FIRST_HDR) begin
          rd_off_next = hdr;
          state_next  = S_FBHDR;
        end else begin
          state_next = S_FBRD;
        end
      end
      // Backward merge: header of the current start, then the footer below it.
      S_FBHDR: begin
        if (h[1:0] == 2'b00) begin
          rd_off_next = start - CW'(4);
          state_next  = S_FBPSZ;
        end else begin
          state_next = S_FBRD;
        end
      end
      S_FBPSZ: begin
        if (h < CW'(8) || h[2:0] != 3'd0 || h > start - FIRST_HDR) begin
          state_next = S_FBRD;
        end else begin
          start_next = start - h;
          if ((start - h) > FIRST_HDR) begin
            rd_off_next = start - h;
            state_next  = S_FBHDR;
          end else begin
            state_next = S_FBRD;
          end
        end
      end
      S_FBRD: begin
        rd_off_next = start;
        state_next  = S_FBWHDR;
      end
      S_FBWHDR: begin
        wr_en      = 1'b1;
        wr_off     = start;
        wr_val     = merged | (h & CW'(2));
        state_next = S_FBWFTR;
      end
      S_FBWFTR: begin
        wr_en           = 1'b1;
        wr_off          = hdr + total - CW'(4);
        wr_val          = merged;
        res_status_next = ST_OK;
        res_off_next    = '0;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // RAM write port: the clearing pass after reset, otherwise the sequencer.
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      if (clr_idx == IDX_HDR) begin
        ram_wdata = INIT_HDR;
      end else if (clr_idx == IDX_FTR) begin
        ram_wdata = INIT_FTR;
      end else if (clr_idx == IDX_END) begin
        ram_wdata = INIT_END;
      end else begin
        ram_wdata = '0;
      end
    end else begin
      ram_we    = wr_en;
      ram_waddr = widx(wr_off);
      ram_wdata = wr_val[WORD_W-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      if (state == S_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the response register.
  always_ff @(posedge clk) begin
    rd_off     <= rd_off_next;
    need       <= need_next;
    hdr        <= hdr_next;
    best       <= best_next;
    bestsz     <= bestsz_next;
    best_pbit  <= best_pbit_next;
    found      <= found_next;
    total      <= total_next;
    h_pbit     <= h_pbit_next;
    nx_val     <= nx_val_next;
    start      <= start_next;
    res_off    <= res_off_next;
    res_status <= res_status_next;
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_off    <= res_off;
      out_status <= res_status;
    end
  end

endmodule

// ===== tb/sv/heap_reply_checker.sv =====
// Checker for the heap allocator: watches both channels, predicts every response and compares.
module heap_reply_checker import bfha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bfha_req_if         req,
  bfha_rsp_if         rsp,
  output int unsigned fail_count,
  output int unsigned owed,
  output int unsigned placed,
  output int unsigned status_seen [8]
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
  localparam int unsigned FIRST_HDR  = 4;
  localparam int unsigned END_OFF    = HEAP_BYTES - 4;
  localparam int unsigned TAG_BITS   = 32'b11;
  localparam int unsigned USED_BIT   = 32'b01;
  localparam int unsigned PREV_BIT   = 32'b10;
  localparam int unsigned GRAIN      = 8;
  localparam int unsigned HDR_BYTES  = 4;

  typedef struct {
    logic              was_alloc;
    logic [ROFF_W-1:0] offset;
    status_t           status;
  } reply_t;

  // Private copy of the heap memory, one header or footer per word.
  logic [15:0] heap_mem [HEAP_WORDS];
  reply_t      replies_due [$];
  int unsigned faults;
  int unsigned placed_n;
  int unsigned tally [8];
  int unsigned reply_idx;

  function automatic int unsigned peek(input int unsigned off);
    int unsigned idx;
    idx = off >> 2;
    return (idx < HEAP_WORDS) ? int'(heap_mem[idx]) : 0;
  endfunction

  function automatic void poke(input int unsigned off, input int unsigned val);
    int unsigned idx;
    idx = off >> 2;
    if (idx < HEAP_WORDS) begin
      heap_mem[idx] = val[15:0];
    end
  endfunction

  // One free block spanning the region, its footer, and the end mark.
  function automatic void build_empty_heap();
    foreach (heap_mem[i]) begin
      heap_mem[i] = '0;
    end
    poke(FIRST_HDR, (HEAP_BYTES - 8) | PREV_BIT);
    poke(END_OFF - 4, HEAP_BYTES - 8);
    poke(END_OFF, 1);
  endfunction

  // Best fit: the smallest free block that holds the rounded request, lowest on a tie.
  function automatic status_t place_block(input int unsigned nbytes,
                                          output int unsigned payload);
    int unsigned need, off, hdr, sz, best, best_sz, nxt;
    bit hit;
    payload = 0;
    best    = 0;
    best_sz = 32'hFFFF_FFFF;
    hit     = 1'b0;
    if (nbytes == 0) begin
      return ST_BADSIZE;
    end
    need = (nbytes + HDR_BYTES + GRAIN - 1) & ~(GRAIN - 1);
    off  = FIRST_HDR;
    while (off < END_OFF) begin
      hdr = peek(off);
      sz  = hdr & ~TAG_BITS;
      if (sz == 0) begin
        break;
      end
      if ((hdr & USED_BIT) == 0 && sz >= need && sz < best_sz) begin
        best    = off;
        best_sz = sz;
        hit     = 1'b1;
      end
      off += sz;
    end
    if (!hit) begin
      return ST_NOFIT;
    end
    // Split off the tail as a new free block with its own footer.
    if (best_sz > need) begin
      poke(best + need, (best_sz - need) | PREV_BIT);
      poke(best + best_sz - HDR_BYTES, best_sz - need);
    end
    poke(best, need | (peek(best) & PREV_BIT) | USED_BIT);
    nxt = best + need;
    if (nxt < END_OFF && peek(nxt) != 1) begin
      poke(nxt, peek(nxt) | PREV_BIT);
    end
    payload = best + HDR_BYTES;
    return ST_OK;
  endfunction

  // Validate the pointer, then merge with free neighbours after and before the block.
  function automatic status_t release_block(input int unsigned ptr);
    int unsigned hdr, off, sz, h, hn, total, nxt, start, psz;
    bit listed;
    listed = 1'b0;
    if (ptr == 0 || (ptr & (GRAIN - 1)) != 0 || ptr >= END_OFF) begin
      return ST_BADPTR;
    end
    hdr = ptr - HDR_BYTES;
    off = FIRST_HDR;
    while (off < END_OFF) begin
      sz = peek(off) & ~TAG_BITS;
      if (off == hdr) begin
        listed = 1'b1;
        break;
      end
      if (sz == 0 || off > hdr) begin
        break;
      end
      off += sz;
    end
    if (!listed) begin
      return ST_BADPTR;
    end
    h = peek(hdr);
    if ((h & USED_BIT) == 0) begin
      return ST_FREED;
    end

    // Absorb every free block that follows.
    total = h & ~TAG_BITS;
    nxt   = hdr + total;
    while (nxt < END_OFF) begin
      hn = peek(nxt);
      sz = hn & ~TAG_BITS;
      if ((hn & USED_BIT) != 0 || sz == 0) begin
        break;
      end
      total += sz;
      nxt   += sz;
    end
    poke(hdr, total | (h & PREV_BIT));
    poke(hdr + total - HDR_BYTES, total);
    if (nxt < END_OFF) begin
      poke(nxt, (peek(nxt) & ~TAG_BITS) | USED_BIT);
    end

    // Walk back over free predecessors through their footers.
    start = hdr;
    while (start > FIRST_HDR && (peek(start) & TAG_BITS) == 0) begin
      psz = peek(start - HDR_BYTES);
      if (psz < GRAIN || (psz & (GRAIN - 1)) != 0 || psz > start - FIRST_HDR) begin
        break;
      end
      start -= psz;
    end
    total += hdr - start;
    poke(start, total | (peek(start) & PREV_BIT));
    poke(hdr + (total - (hdr - start)) - HDR_BYTES, total);
    return ST_OK;
  endfunction

  function automatic reply_t settle_request(input logic act,
                                           input logic [REQ_BYTES_W-1:0] nbytes,
                                           input logic [POFF_W-1:0] ptr);
    reply_t r;
    int unsigned payload;
    payload     = 0;
    r.was_alloc = (act == ACT_ALLOC);
    if (act == ACT_ALLOC) begin
      r.status = place_block(nbytes, payload);
    end else begin
      r.status = release_block(ptr);
    end
    r.offset = payload[ROFF_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch on response %0d: %s", $realtime, reply_idx, what);
    faults++;
  endtask

  // Responses are matched before requests are taken: a response at an edge always
  // belongs to a request accepted at an earlier edge.
  always @(posedge clk) begin
    reply_t due;
    if (rst) begin
      build_empty_heap();
      replies_due.delete();
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("no request outstanding (offset %0d, status %0d)",
                                    rsp.result_offset, rsp.status));
        end else begin
          due = replies_due.pop_front();
          if (rsp.status !== due.status) begin
            report_mismatch($sformatf("status %0d, predicted %0d", rsp.status, due.status));
          end
          if (rsp.result_offset !== due.offset) begin
            report_mismatch($sformatf("offset %0d, predicted %0d",
                                      rsp.result_offset, due.offset));
          end
          tally[due.status]++;
          if (due.was_alloc && due.status == ST_OK) begin
            placed_n++;
          end
        end
        reply_idx++;
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        replies_due.push_back(settle_request(req.action, req.request_bytes,
                                             req.payload_offset));
      end
    end
    owed        <= replies_due.size();
    fail_count  <= faults;
    placed      <= placed_n;
    status_seen <= tally;
  end

endmodule

// ===== tb/sv/best_fit_heap_allocator_test.sv =====
// Testbench top for the best-fit heap allocator: clock, reset, traffic on both channels, verdict.
module best_fit_heap_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bfha_pkg::*;

  localparam int unsigned HALF_PERIOD  = 2;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned FREED_DEPTH  = 16;
  localparam int unsigned MAX_OFFSET   = (1 << POFF_W) - 1;
  localparam int unsigned MAX_REQUEST  = 4096;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bfha_req_if req ();
  bfha_rsp_if rsp ();

  int unsigned fail_count;
  int unsigned owed;
  int unsigned placed;
  int unsigned status_seen [8];

  int unsigned sent;
  int unsigned cycles;
  int unsigned alloc_pct = 60;
  int unsigned squeeze_asked;
  bit          steady;
  bit          squeezing;
  int unsigned live_ptrs [$];
  int unsigned freed_ptrs [$];

  best_fit_heap_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  heap_reply_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .owed        (owed),
    .placed      (placed),
    .status_seen (status_seen)
  );

  always #HALF_PERIOD clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len(input bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Present one request from a falling edge and hold it until its transfer.
  task automatic offer(input logic act, input int unsigned nbytes, input int unsigned ptr);
    int unsigned idle;
    req.valid          = 1'b1;
    req.action         = act;
    req.request_bytes  = nbytes[REQ_BYTES_W-1:0];
    req.payload_offset = ptr[POFF_W-1:0];
    do @(posedge clk); while (req.ready !== 1'b1);
    sent++;
    @(negedge clk);
    idle = gap_len(steady || squeezing);
    if (idle > 0) begin
      req.valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
  endtask

  // Learn live payload offsets from granted allocations.
  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1 && rsp.status == ST_OK &&
        rsp.result_offset != '0) begin
      live_ptrs.push_back(rsp.result_offset);
    end
  end

  // Give up at a generous cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Response side: random back-pressure, plus the long hold-offs asked for by the sender.
  initial begin
    int unsigned served;
    int unsigned idle;
    served    = 0;
    rsp.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (squeeze_asked != served) begin
        served    = squeeze_asked;
        squeezing = 1'b1;
        rsp.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        squeezing = 1'b0;
      end else begin
        idle = gap_len(steady);
        if (idle > 0) begin
          rsp.ready = 1'b0;
          repeat (idle) @(negedge clk);
        end
        rsp.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Request side: reset, directed sequence, random traffic, drain and verdict.
  initial begin
    int unsigned roll;
    int unsigned pick;
    int unsigned ptr;
    int unsigned nbytes;
    req.valid          = 1'b0;
    req.action         = ACT_ALLOC;
    req.request_bytes  = '0;
    req.payload_offset = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Rejections on a fresh heap: zero size, oversize, null, misaligned, off-list, not in use.
    offer(ACT_ALLOC, 0, 0);
    offer(ACT_ALLOC, MAX_REQUEST, MAX_OFFSET);
    offer(ACT_FREE, 0, 0);
    offer(ACT_FREE, 0, MAX_OFFSET);
    offer(ACT_FREE, 0, 4088);
    offer(ACT_FREE, 0, 8);
    // Exact fit of the whole region, then nothing left, then back to empty.
    offer(ACT_ALLOC, 4084, 0);
    offer(ACT_ALLOC, 1, 0);
    offer(ACT_FREE, 0, 8);
    // A row of small blocks and one big one that leaves a free tail.
    offer(ACT_ALLOC, 1, 0);
    offer(ACT_ALLOC, 4, 0);
    offer(ACT_ALLOC, 5, 0);
    offer(ACT_ALLOC, 20, 0);
    offer(ACT_ALLOC, 3000, 0);
    // Pointer into the middle of a block, then frees merging back and forward.
    offer(ACT_FREE, 0, 48);
    offer(ACT_FREE, 0, 16);
    offer(ACT_FREE, 0, 24);
    offer(ACT_FREE, 0, 8);
    offer(ACT_FREE, 0, 16);
    // Best fit picks the small hole over the big tail and splits it.
    offer(ACT_ALLOC, 8, 0);
    offer(ACT_ALLOC, 1030, 0);
    offer(ACT_FREE, 0, 64);
    offer(ACT_FREE, 0, 40);
    offer(ACT_ALLOC, 4, 0);
    offer(ACT_FREE, 0, 8);
    offer(ACT_FREE, 0, 24);
    while (owed != 0) @(negedge clk);
    live_ptrs.delete();
    freed_ptrs.delete();

    // Random traffic in phases that lean towards filling or emptying the heap.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        steady = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 2))
          0: alloc_pct = 85;
          1: alloc_pct = 60;
          default: alloc_pct = 30;
        endcase
      end
      if (i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3) begin
        squeeze_asked++;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // Noise: a zero size, or a pointer anywhere in the region.
        if (roll == 0) begin
          offer(ACT_ALLOC, 0, $urandom_range(0, MAX_OFFSET));
        end else begin
          offer(ACT_FREE, $urandom_range(0, MAX_REQUEST), $urandom_range(0, MAX_OFFSET));
        end
      end else if (live_ptrs.size() == 0 || roll < alloc_pct) begin
        // Mostly small requests, some medium, a few up to the whole region.
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          nbytes = $urandom_range(1, 48);
        end else if (roll < 88) begin
          nbytes = $urandom_range(49, 400);
        end else if (roll < 97) begin
          nbytes = $urandom_range(401, 2000);
        end else begin
          nbytes = $urandom_range(2001, MAX_REQUEST);
        end
        offer(ACT_ALLOC, nbytes, $urandom_range(0, MAX_OFFSET));
      end else begin
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, live_ptrs.size() - 1);
        if (roll < 80) begin
          ptr = live_ptrs[pick];
          live_ptrs.delete(pick);
          freed_ptrs.push_back(ptr);
          if (freed_ptrs.size() > FREED_DEPTH) begin
            void'(freed_ptrs.pop_front());
          end
        end else if (roll < 88 && freed_ptrs.size() != 0) begin
          // Likely a second release of the same block.
          ptr = freed_ptrs[$urandom_range(0, freed_ptrs.size() - 1)];
        end else if (roll < 95) begin
          // Misaligned or pointing inside a live block.
          ptr = live_ptrs[pick] + 4 * $urandom_range(1, 6);
        end else begin
          ptr = $urandom_range(0, MAX_OFFSET);
        end
        offer(ACT_FREE, $urandom_range(0, MAX_REQUEST), ptr);
      end
    end
    req.valid = 1'b0;

    while (owed != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d requests: %0d blocks placed, %0d blocks released.",
             sent, placed, status_seen[ST_OK] - placed);
    $display("Refused %0d for no fit, %0d bad size, %0d bad pointer, %0d already free.",
             status_seen[ST_NOFIT], status_seen[ST_BADSIZE], status_seen[ST_BADPTR],
             status_seen[ST_FREED]);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
